@@ rtl/modular_add_sub_double_core_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the modular add / subtract / double core.
// Each macro expects clk and rst_n to be visible where it is used.
// ---------------------------------------------------------------------------
`ifndef MODULAR_ADD_SUB_DOUBLE_CORE_DEFINES_SVH
`define MODULAR_ADD_SUB_DOUBLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every clock edge outside of reset.
`define MAS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("modular_add_sub_double_core: check failed");

// Checked on every clock edge, reset included.
`define MAS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("modular_add_sub_double_core: check failed");

`else

`define MAS_ASSERT(lbl, prop)
`define MAS_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

@@ rtl/mas_pkg.sv @@
// ---------------------------------------------------------------------------
// mas_pkg
// Shared constants, types and limb arithmetic for the modular core.
// ---------------------------------------------------------------------------
package mas_pkg;

  // Operand geometry.
  localparam int MAX_LIMBS = 8;
  localparam int LIMB_W    = 32;
  localparam int CNT_W     = $clog2(MAX_LIMBS + 1);
  localparam int IDX_W     = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
  localparam int ACT_W     = 2;

  // Operation codes; any code with the double bit set acts as double.
  localparam logic [ACT_W-1:0] OP_ADD     = 2'd0;
  localparam logic [ACT_W-1:0] OP_SUB     = 2'd1;
  localparam logic [ACT_W-1:0] OP_DBL     = 2'd2;
  localparam int               OP_DBL_BIT = 1;

  // One limb of each operand as it is stored.
  typedef struct packed {
    logic [LIMB_W-1:0] m;
    logic [LIMB_W-1:0] b;
    logic [LIMB_W-1:0] a;
  } limb_set_t;

  // Control from the sequencer to the load-time compare unit.
  typedef struct packed {
    logic we;
    logic first;
  } load_ctrl_t;

  // Control from the sequencer to the emission datapath.
  typedef struct packed {
    logic start;
    logic step;
  } emit_ctrl_t;

  // Load limbs, read the low limb from the buffer, then emit the result.
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PRIME,
    ST_EMIT
  } state_t;

  // Limb add with carry in; the top bit is the carry out.
  function automatic logic [LIMB_W:0] add_limb(input logic [LIMB_W-1:0] x,
                                               input logic [LIMB_W-1:0] y,
                                               input logic              cin);
    return {1'b0, x} + {1'b0, y} + {{LIMB_W{1'b0}}, cin};
  endfunction

  // Limb subtract with borrow in; the top bit is the borrow out.
  function automatic logic [LIMB_W:0] sub_limb(input logic [LIMB_W-1:0] x,
                                               input logic [LIMB_W-1:0] y,
                                               input logic              bin);
    return {1'b0, x} - {1'b0, y} - {{LIMB_W{1'b0}}, bin};
  endfunction

endpackage

@@ rtl/mas_limb_store.sv @@
// ---------------------------------------------------------------------------
// mas_limb_store
// Generic RAM with one write port and one registered read port.
// ---------------------------------------------------------------------------
module mas_limb_store #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; entries hold payload only.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/mas_select.sv @@
// ---------------------------------------------------------------------------
// mas_select
// Runs the carry and borrow chains of all operations while limbs load and
// decides, at the last limb, whether the reduced form is the result.
// ---------------------------------------------------------------------------
module mas_select (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mas_pkg::load_ctrl_t           ctrl,
  input  logic [mas_pkg::ACT_W-1:0]     action,
  input  mas_pkg::limb_set_t            limbs,
  output logic                          sel
);
  import mas_pkg::*;

  logic              add_c_r, add_bw_r, dbl_c_r, dbl_bw_r, sub_bw_r;
  logic              add_c_in, add_bw_in, dbl_c_in, dbl_bw_in, sub_bw_in;
  logic [LIMB_W:0]   add_s, add_d, dbl_s, dbl_d, sub_d;
  logic              add_c, add_bw, dbl_c, dbl_bw, sub_bw;

  // Chains restart on the first limb of an operand.
  always_comb begin
    add_c_in  = ctrl.first ? 1'b0 : add_c_r;
    add_bw_in = ctrl.first ? 1'b0 : add_bw_r;
    dbl_c_in  = ctrl.first ? 1'b0 : dbl_c_r;
    dbl_bw_in = ctrl.first ? 1'b0 : dbl_bw_r;
    sub_bw_in = ctrl.first ? 1'b0 : sub_bw_r;
  end

  // Sum, sum minus modulus, and difference for this limb.
  always_comb begin
    add_s = add_limb(limbs.a, limbs.b, add_c_in);
    add_d = sub_limb(add_s[LIMB_W-1:0], limbs.m, add_bw_in);
    dbl_s = add_limb(limbs.a, limbs.a, dbl_c_in);
    dbl_d = sub_limb(dbl_s[LIMB_W-1:0], limbs.m, dbl_bw_in);
    sub_d = sub_limb(limbs.a, limbs.b, sub_bw_in);
  end

  // A dropped limb leaves the chains as they were.
  always_comb begin
    add_c  = ctrl.we ? add_s[LIMB_W] : add_c_r;
    add_bw = ctrl.we ? add_d[LIMB_W] : add_bw_r;
    dbl_c  = ctrl.we ? dbl_s[LIMB_W] : dbl_c_r;
    dbl_bw = ctrl.we ? dbl_d[LIMB_W] : dbl_bw_r;
    sub_bw = ctrl.we ? sub_d[LIMB_W] : sub_bw_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_c_r  <= 1'b0;
      add_bw_r <= 1'b0;
      dbl_c_r  <= 1'b0;
      dbl_bw_r <= 1'b0;
      sub_bw_r <= 1'b0;
    end else begin
      add_c_r  <= add_c;
      add_bw_r <= add_bw;
      dbl_c_r  <= dbl_c;
      dbl_bw_r <= dbl_bw;
      sub_bw_r <= sub_bw;
    end
  end

  // Reduce when the sum overflowed or is at least m; for subtract when a < b.
  always_comb begin
    if (action[OP_DBL_BIT]) begin
      sel = dbl_c || !dbl_bw;
    end else if (action == OP_SUB) begin
      sel = sub_bw;
    end else begin
      sel = add_c || !add_bw;
    end
  end

endmodule

@@ rtl/mas_emit.sv @@
// ---------------------------------------------------------------------------
// mas_emit
// Recomputes the chosen operation one limb per step, low limb first, and
// hands out either the plain or the reduced limb.
// ---------------------------------------------------------------------------
module mas_emit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mas_pkg::emit_ctrl_t           ctrl,
  input  logic [mas_pkg::ACT_W-1:0]     op,
  input  logic                          sel,
  input  mas_pkg::limb_set_t            limbs,
  output logic [mas_pkg::LIMB_W-1:0]    result
);
  import mas_pkg::*;

  logic              c1_r, c1_nxt;
  logic              c2_r, c2_nxt;
  logic [LIMB_W-1:0] y;
  logic [LIMB_W:0]   p, q;

  // First stage adds or subtracts the operands, second stage folds in m.
  always_comb begin
    y = op[OP_DBL_BIT] ? limbs.a : limbs.b;
    if (op == OP_SUB) begin
      p = sub_limb(limbs.a, limbs.b, c1_r);
      q = add_limb(p[LIMB_W-1:0], limbs.m, c2_r);
    end else begin
      p = add_limb(limbs.a, y, c1_r);
      q = sub_limb(p[LIMB_W-1:0], limbs.m, c2_r);
    end
    result = sel ? q[LIMB_W-1:0] : p[LIMB_W-1:0];
  end

  // Chain registers clear at the start of a result and advance per limb.
  always_comb begin
    c1_nxt = c1_r;
    c2_nxt = c2_r;
    if (ctrl.start) begin
      c1_nxt = 1'b0;
      c2_nxt = 1'b0;
    end else if (ctrl.step) begin
      c1_nxt = p[LIMB_W];
      c2_nxt = q[LIMB_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= 1'b0;
      c2_r <= 1'b0;
    end else begin
      c1_r <= c1_nxt;
      c2_r <= c2_nxt;
    end
  end

endmodule

@@ rtl/modular_add_sub_double_core.sv @@
// ---------------------------------------------------------------------------
// modular_add_sub_double_core
// Multi-limb modular add, subtract and double for field arithmetic.
// ---------------------------------------------------------------------------
// Usage:
// Each input item carries one 32-bit limb of a, b and m, low limb first,
// with the operation code in in_tuser and in_tlast on the top limb. Up to
// eight limbs are kept; further limbs are dropped, but a last-marked item
// still closes the operand.
// While limbs load, the carry and borrow chains of every operation run in
// parallel, so the reduce decision is ready when the last limb arrives.
// The result then leaves as n items, low limb first, out_tlast on the top
// limb. Before the first result limb, ST_PRIME reads the low limb from the
// buffer, and ST_EMIT then registers each result limb in the output register.
// One result limb follows per cycle while out_tready is high.
// An operand of n limbs is loaded, its low limb is read in ST_PRIME, and then
// the emission walk over the limb buffer hands out the result; a new operand
// is taken only after that walk ends. in_tready is low from the last input
// item on, and rises again as soon as the final limb sits in the output
// register.
// A stalled receiver holds the output register and the emission walk.
// Reset clears the limb count, the operation and the output valid flag.
// ---------------------------------------------------------------------------
`include "modular_add_sub_double_core_defines.svh"

module modular_add_sub_double_core (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // a_limb [31:0], b_limb [63:32], m_limb [95:64]
  input  logic [1:0]  in_tuser,   // action [1:0]
  input  logic        in_tlast,
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // result_limb [31:0]
  output logic        out_tlast
);
  import mas_pkg::*;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [ACT_W-1:0]  op_r, op_nxt;
  logic              sel_r, sel_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_last_r, out_last_nxt;
  logic [LIMB_W-1:0] out_data_r, out_data_nxt;

  logic              in_acc;
  logic              slot_free;
  logic              emit_last;
  logic              sel_load;
  logic [LIMB_W-1:0] emit_limb;
  limb_set_t         wr_limbs, rd_limbs;
  load_ctrl_t        load_ctrl;
  emit_ctrl_t        emit_ctrl;

  // Unpack the input item.
  assign wr_limbs.a = in_tdata[LIMB_W-1:0];
  assign wr_limbs.b = in_tdata[2*LIMB_W-1:LIMB_W];
  assign wr_limbs.m = in_tdata[3*LIMB_W-1:2*LIMB_W];

  assign in_tready  = (state_r == ST_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign slot_free  = !out_valid_r || out_tready;
  assign emit_last  = (idx_r == (n_r - CNT_W'(1)));

  assign load_ctrl.we    = in_acc && (cnt_r < CNT_W'(MAX_LIMBS));
  assign load_ctrl.first = (cnt_r == '0);

  // The read address runs one step ahead, so the read data holds limb idx_r.
  mas_limb_store #(
    .WIDTH ($bits(limb_set_t)),
    .DEPTH (MAX_LIMBS)
  ) u_store (
    .clk   (clk),
    .we    (load_ctrl.we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (wr_limbs),
    .raddr (idx_nxt[IDX_W-1:0]),
    .rdata (rd_limbs)
  );

  mas_select u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (load_ctrl),
    .action (in_tuser),
    .limbs  (wr_limbs),
    .sel    (sel_load)
  );

  mas_emit u_emit (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (emit_ctrl),
    .op     (op_r),
    .sel    (sel_r),
    .limbs  (rd_limbs),
    .result (emit_limb)
  );

  // Sequencer: load limbs, read the low limb, then walk them once to emit.
  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    n_nxt           = n_r;
    idx_nxt         = idx_r;
    op_nxt          = op_r;
    sel_nxt         = sel_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_last_nxt    = out_last_r;
    out_data_nxt    = out_data_r;
    emit_ctrl.start = 1'b0;
    emit_ctrl.step  = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (load_ctrl.we) begin
            cnt_nxt = CNT_W'(cnt_r + CNT_W'(1));
          end
          if (in_tlast) begin
            n_nxt           = load_ctrl.we ? CNT_W'(cnt_r + CNT_W'(1)) : cnt_r;
            cnt_nxt         = '0;
            idx_nxt         = '0;
            op_nxt          = in_tuser;
            sel_nxt         = sel_load;
            emit_ctrl.start = 1'b1;
            state_nxt       = ST_PRIME;
          end
        end
      end
      ST_PRIME: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          emit_ctrl.step = 1'b1;
          out_valid_nxt  = 1'b1;
          out_data_nxt   = emit_limb;
          out_last_nxt   = emit_last;
          idx_nxt        = CNT_W'(idx_r + CNT_W'(1));
          if (emit_last) begin
            state_nxt = ST_LOAD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      cnt_r       <= '0;
      n_r         <= '0;
      idx_r       <= '0;
      op_r        <= OP_ADD;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      idx_r       <= idx_nxt;
      op_r        <= op_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // The limb count never runs past the buffer depth.
  `MAS_ASSERT(a_cnt_range, cnt_r <= CNT_W'(MAX_LIMBS))
  // An emitted result has between one and the buffer depth of limbs.
  `MAS_ASSERT(a_n_range, (state_r == ST_EMIT) |-> ((n_r != '0) && (n_r <= CNT_W'(MAX_LIMBS))))
  // The emission walk stays inside the stored limbs.
  `MAS_ASSERT(a_idx_range, (state_r == ST_EMIT) |-> (idx_r < n_r))
  // Handing out the top limb ends the result and marks it last.
  `MAS_ASSERT(a_last_end, ((state_r == ST_EMIT) && slot_free && emit_last) |=> ((state_r == ST_LOAD) && out_tvalid && out_tlast))
  // Reset empties the output register.
  `MAS_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_tvalid)

endmodule
